[design/bca_pkg.sv]
// Shared types and constants of the contiguous page allocator.
package bca_pkg;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADCNT  = 2'd1;
	localparam logic [1:0] ST_BADZONE = 2'd2;
	localparam logic [1:0] ST_NORUN   = 2'd3;

	// Operation kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam logic [12:0] CNT_MAX = 13'd8191;
	localparam int CQ_DEPTH = 8;
	localparam int CQ_PW    = 3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic in_ready;
		logic take;
		logic clr_start;
		logic check;
		logic s_eval;
		logic set_cur;
		logic set_prev;
		logic f_step;
		logic f_wr;
		logic c_wr;
		logic resp;
	} bca_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic accept;
		logic clr_pend;
		logic chk_done;
		logic chk_free;
		logic s_found;
		logic s_last;
		logic s_span;
		logic f_flush;
		logic f_done;
		logic f_end;
		logic c_last;
		logic out_free;
	} bca_sts_t;

endpackage

[design/bca_if.sv]
// Request and response channel interfaces of the page allocator.
interface bca_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [1:0]  zone;
	logic [5:0]  count;
	logic [11:0] page_index;

	modport source (output valid, kind, zone, count, page_index, input ready);
	modport sink (input valid, kind, zone, count, page_index, output ready);
endinterface

interface bca_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] first_page;
	logic [12:0] zone_free_left;

	modport source (output valid, status, first_page, zone_free_left, input ready);
	modport sink (input valid, status, first_page, zone_free_left, output ready);
endinterface

[design/bitmap_contiguous_page_allocator.sv]
// Top level of the bitmap first-fit contiguous page allocator.
//
// Usage: requests arrive on in_ch (kind, zone, count, page_index); each one
// yields exactly one response item on out_ch (status, first_page,
// zone_free_left). Zone bounds are written on the cfg_we/cfg_index/cfg_data
// port; each bound write reloads the zone's free counter at once and, when
// the new range is not empty, queues a sweep that clears the zone's bitmap
// bits (up to 8 sweeps queued). A rejected request goes from its check
// straight to its response. An allocate reads, then searches one bitmap word
// per step (64 pages a word, so up to 64 words for a 4096-page zone), then
// writes one or two words. A free steps one page at a time and reads and
// writes back each bitmap word whose bits it clears. A bound sweep reads and
// writes each word of the zone, and in_ch.ready stays low meanwhile.
// Throughput is one item at a time, set by the single bitmap memory port and
// the word-at-a-time search; a new item is taken while a response still
// waits in the output register.
// Reset clears the bitmap (every page free), bounds and counters to zero.
// When out_ch stalls, the response holds and the next one waits in the
// controller until the output register drains.
module bitmap_contiguous_page_allocator #(
	parameter int PAGES     = 4096,
	parameter int NUM_ZONES = 3,
	parameter int MAX_RUN   = 63
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bca_req_if.sink                         in_ch,
	bca_rsp_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [bca_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bca_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bca_pkg::*;

	bca_cmd_t cmd;
	bca_sts_t sts;

	// Sequence each item and each bound sweep
	bca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Hold the bitmap, zones and the search and free walks
	bca_dp #(
		.PAGES     (PAGES),
		.NUM_ZONES (NUM_ZONES),
		.MAX_RUN   (MAX_RUN)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.in_valid           (in_ch.valid),
		.in_kind            (in_ch.kind),
		.in_zone            (in_ch.zone),
		.in_count           (in_ch.count),
		.in_page_index      (in_ch.page_index),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.out_valid          (out_ch.valid),
		.out_ready          (out_ch.ready),
		.out_status         (out_ch.status),
		.out_first_page     (out_ch.first_page),
		.out_zone_free_left (out_ch.zone_free_left)
	);

	assign in_ch.ready = cmd.in_ready;

endmodule

[design/bca_ctrl.sv]
// Controller state machine of the page allocator.
module bca_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  bca_pkg::bca_sts_t sts,
	output bca_pkg::bca_cmd_t cmd
);
	import bca_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_SRD   = 4'd2;
	localparam logic [3:0] S_SEVAL = 4'd3;
	localparam logic [3:0] S_SETC  = 4'd4;
	localparam logic [3:0] S_SETP  = 4'd5;
	localparam logic [3:0] S_FSTEP = 4'd6;
	localparam logic [3:0] S_FRD   = 4'd7;
	localparam logic [3:0] S_FWR   = 4'd8;
	localparam logic [3:0] S_CRD   = 4'd9;
	localparam logic [3:0] S_CWR   = 4'd10;
	localparam logic [3:0] S_RESP  = 4'd11;

	logic [3:0] state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (sts.accept) state_nx = S_CHECK;
				else if (sts.clr_pend) state_nx = S_CRD;
			end
			S_CHECK: begin
				priority if (sts.chk_done) state_nx = S_RESP;
				else if (sts.chk_free) state_nx = S_FSTEP;
				else state_nx = S_SRD;
			end
			S_SRD: state_nx = S_SEVAL;
			S_SEVAL: begin
				priority if (sts.s_found) state_nx = S_SETC;
				else if (sts.s_last) state_nx = S_RESP;
				else state_nx = S_SEVAL;
			end
			S_SETC: state_nx = sts.s_span ? S_SETP : S_RESP;
			S_SETP: state_nx = S_RESP;
			S_FSTEP: begin
				priority if (sts.f_flush) state_nx = S_FRD;
				else if (sts.f_done) state_nx = S_RESP;
				else state_nx = S_FSTEP;
			end
			S_FRD: state_nx = S_FWR;
			S_FWR: state_nx = sts.f_end ? S_RESP : S_FSTEP;
			S_CRD: state_nx = S_CWR;
			S_CWR: state_nx = sts.c_last ? S_IDLE : S_CRD;
			S_RESP: begin
				if (sts.out_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.in_ready  = (state_q == S_IDLE) && !sts.clr_pend;
		cmd.take      = (state_q == S_IDLE) && sts.accept;
		cmd.clr_start = (state_q == S_IDLE) && !sts.accept && sts.clr_pend;
		cmd.check     = (state_q == S_CHECK);
		cmd.s_eval    = (state_q == S_SEVAL);
		cmd.set_cur   = (state_q == S_SETC);
		cmd.set_prev  = (state_q == S_SETP);
		cmd.f_step    = (state_q == S_FSTEP);
		cmd.f_wr      = (state_q == S_FWR);
		cmd.c_wr      = (state_q == S_CWR);
		cmd.resp      = (state_q == S_RESP);
	end

endmodule

[design/bca_dp.sv]
// Datapath of the page allocator: bitmap memory, zone registers, run search.
module bca_dp #(
	parameter int PAGES     = 4096,
	parameter int NUM_ZONES = 3,
	parameter int MAX_RUN   = 63
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bca_pkg::bca_cmd_t                 cmd,
	output bca_pkg::bca_sts_t                 sts,
	input  logic                              in_valid,
	input  logic                              in_kind,
	input  logic [1:0]                        in_zone,
	input  logic [5:0]                        in_count,
	input  logic [11:0]                       in_page_index,
	input  logic                              cfg_we,
	input  logic [bca_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bca_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        out_status,
	output logic [11:0]                       out_first_page,
	output logic [12:0]                       out_zone_free_left
);
	import bca_pkg::*;

	localparam int MAP_WORDS = (PAGES + 63) / 64;
	localparam int AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PW  = $clog2(PAGES + 8192);
	localparam int WDW = PW - 6;
	localparam int ZIW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;

	// Bitmap storage
	logic [63:0]    mem [MAP_WORDS];
	logic           vld_q [MAP_WORDS];
	logic [63:0]    rd_q;
	logic           rdv_q;
	logic [AW-1:0]  ra, wa;
	logic           we;
	logic [63:0]    wd;
	logic [63:0]    rdata;

	// Zone state
	logic [11:0] zfirst_q [NUM_ZONES];
	logic [12:0] zend_q   [NUM_ZONES];
	logic [12:0] zcnt_q   [NUM_ZONES];

	// Clear queue
	logic [PW-1:0]  cq_lo_q [CQ_DEPTH];
	logic [PW-1:0]  cq_hi_q [CQ_DEPTH];
	logic [CQ_PW-1:0] cq_wp_q, cq_rp_q;
	logic [CQ_PW:0]   cq_n_q;

	// Item and walk registers
	logic          kind_q;
	logic [1:0]    zone_q;
	logic [5:0]    count_q;
	logic [11:0]   pidx_q;
	logic [WDW-1:0] w_q;
	logic [PW-1:0] lo_q, hi_q, p_q, sp_q, ep_q;
	logic [5:0]    n_q;
	logic [63:0]   mask_q, prev_free_q, prev_raw_q, cur_raw_q;
	logic [1:0]    res_status_q;
	logic [11:0]   res_first_q;
	logic [12:0]   res_left_q;
	logic          ov_q;

	function automatic logic [PW-1:0] end_clamp(input logic [12:0] e);
		logic [PW-1:0] ex;
		ex = PW'(e);
		return (ex > PW'(PAGES)) ? PW'(PAGES) : ex;
	endfunction

	// Bits of word w that lie in [lo, hi); w is assumed inside the range
	function automatic logic [63:0] rmask(input logic [WDW-1:0] w,
	                                      input logic [PW-1:0] lo,
	                                      input logic [PW-1:0] hi);
		logic [PW-1:0] hm1;
		logic [63:0]   ml, mh;
		hm1 = hi - 1'b1;
		ml = (w == lo[PW-1:6]) ? ({64{1'b1}} << lo[5:0]) : {64{1'b1}};
		mh = (w == hm1[PW-1:6]) ? ({64{1'b1}} >> (6'd63 - hm1[5:0])) : {64{1'b1}};
		return ml & mh;
	endfunction

	assign rdata = rdv_q ? rd_q : 64'd0;

	// Check of a new item
	logic          bad_cnt, bad_zone, short_cnt;
	logic [ZIW-1:0] zs;
	logic [12:0]   cur_cnt;

	always_comb begin
		zs        = zone_q[ZIW-1:0];
		bad_cnt   = (count_q == 6'd0) || (32'(count_q) > MAX_RUN);
		bad_zone  = (kind_q == KIND_ALLOC) && (32'(zone_q) >= NUM_ZONES);
		cur_cnt   = bad_zone ? 13'd0 : zcnt_q[zs];
		short_cnt = (kind_q == KIND_ALLOC) && (cur_cnt < 13'(count_q));
	end

	// Run search over one word plus the free bits of the word before it
	logic [63:0]  free_cur;
	logic [127:0] wv, acc;
	logic [63:0]  hits;
	logic [5:0]   hit_i;
	logic [PW-1:0] ep_nx, sp_nx, hm1_q;

	always_comb begin
		free_cur = ~rdata & rmask(w_q, lo_q, hi_q);
		wv  = {free_cur, prev_free_q};
		acc = {128{1'b1}};
		for (int k = 0; k < 6; k++) begin
			if (count_q[k]) acc = wv & (acc << (1 << k));
			wv = wv & (wv << (1 << k));
		end
		hits  = acc[127:64];
		hit_i = 6'd0;
		for (int i = 63; i >= 0; i--) begin
			if (hits[i]) hit_i = 6'(i);
		end
		ep_nx = {w_q, hit_i} + 1'b1;
		sp_nx = ep_nx - PW'(count_q);
		hm1_q = hi_q - 1'b1;
	end

	// Free walk, one page per step
	logic          f_hit;
	logic [ZIW-1:0] f_z;
	logic [63:0]   mask_nx;
	logic [PW-1:0] p_nx;
	logic          f_last, f_wchg;

	always_comb begin
		f_hit = 1'b0;
		f_z   = '0;
		for (int z = NUM_ZONES - 1; z >= 0; z--) begin
			if (p_q >= PW'(zfirst_q[z]) && p_q < end_clamp(zend_q[z])) begin
				f_hit = 1'b1;
				f_z   = ZIW'(z);
			end
		end
		mask_nx = mask_q | (f_hit ? (64'd1 << p_q[5:0]) : 64'd0);
		p_nx    = p_q + 1'b1;
		f_last  = (n_q == 6'd1);
		f_wchg  = (p_nx[PW-1:6] != w_q);
	end

	// Configuration write decode
	logic           cfg_hit;
	logic [ZIW-1:0] cz;
	logic [11:0]    nf;
	logic [12:0]    ne;
	logic [PW-1:0]  nec;
	logic           cfg_nonempty;
	logic [12:0]    nsize;

	always_comb begin
		cfg_hit      = cfg_we && (32'(cfg_index) < 2 * NUM_ZONES);
		cz           = ZIW'(cfg_index[CFG_IDX_W-1:1]);
		nf           = cfg_index[0] ? zfirst_q[cz] : cfg_data[11:0];
		ne           = cfg_index[0] ? cfg_data[12:0] : zend_q[cz];
		nec          = end_clamp(ne);
		cfg_nonempty = nec > PW'(nf);
		nsize        = cfg_nonempty ? 13'(nec - PW'(nf)) : 13'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int z = 0; z < NUM_ZONES; z++) begin
				zfirst_q[z] <= '0;
				zend_q[z]   <= '0;
				zcnt_q[z]   <= '0;
			end
		end else begin
			if (cfg_hit) begin
				if (cfg_index[0]) zend_q[cz] <= ne;
				else zfirst_q[cz] <= nf;
				zcnt_q[cz] <= nsize;
			end else if (cmd.s_eval && (|hits)) begin
				zcnt_q[zs] <= cur_cnt - 13'(count_q);
			end else if (cmd.f_step && f_hit && (zcnt_q[f_z] < CNT_MAX)) begin
				zcnt_q[f_z] <= zcnt_q[f_z] + 1'b1;
			end
		end
	end

	// Clear queue: ranges to sweep after bound writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cq_wp_q <= '0;
			cq_rp_q <= '0;
			cq_n_q  <= '0;
		end else begin
			if (cfg_hit && cfg_nonempty && (32'(cq_n_q) < CQ_DEPTH)) begin
				cq_wp_q <= cq_wp_q + 1'b1;
			end
			if (cmd.clr_start) cq_rp_q <= cq_rp_q + 1'b1;
			cq_n_q <= cq_n_q
			        + ((cfg_hit && cfg_nonempty && (32'(cq_n_q) < CQ_DEPTH)) ? 1'b1 : 1'b0)
			        - (cmd.clr_start ? 1'b1 : 1'b0);
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_hit && cfg_nonempty) begin
			cq_lo_q[cq_wp_q] <= PW'(nf);
			cq_hi_q[cq_wp_q] <= nec;
		end
	end

	// Item and walk registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q  <= in_kind;
			zone_q  <= in_zone;
			count_q <= in_count;
			pidx_q  <= in_page_index;
		end
		if (cmd.clr_start) begin
			lo_q <= cq_lo_q[cq_rp_q];
			hi_q <= cq_hi_q[cq_rp_q];
			w_q  <= cq_lo_q[cq_rp_q][PW-1:6];
		end
		if (cmd.check) begin
			res_first_q <= '0;
			res_left_q  <= (!bad_cnt && !bad_zone && (kind_q == KIND_ALLOC)) ? cur_cnt : 13'd0;
			priority if (bad_cnt) res_status_q <= ST_BADCNT;
			else if (bad_zone) res_status_q <= ST_BADZONE;
			else if (short_cnt) res_status_q <= ST_NORUN;
			else res_status_q <= ST_OK;
			if (kind_q == KIND_FREE) begin
				p_q    <= PW'(pidx_q);
				n_q    <= count_q;
				mask_q <= '0;
				w_q    <= WDW'(pidx_q[11:6]);
			end else begin
				lo_q        <= PW'(zfirst_q[zs]);
				hi_q        <= end_clamp(zend_q[zs]);
				w_q         <= WDW'(zfirst_q[zs][11:6]);
				prev_free_q <= '0;
			end
		end
		if (cmd.s_eval) begin
			if (|hits) begin
				sp_q        <= sp_nx;
				ep_q        <= ep_nx;
				cur_raw_q   <= rdata;
				res_first_q <= sp_nx[11:0];
				res_left_q  <= cur_cnt - 13'(count_q);
			end else begin
				prev_free_q <= free_cur;
				prev_raw_q  <= rdata;
				w_q         <= w_q + 1'b1;
				if (w_q == hm1_q[PW-1:6]) res_status_q <= ST_NORUN;
			end
		end
		if (cmd.f_step) begin
			p_q    <= p_nx;
			n_q    <= n_q - 1'b1;
			mask_q <= mask_nx;
			if ((f_last || f_wchg) && !(|mask_nx)) w_q <= p_nx[PW-1:6];
		end
		if (cmd.f_wr) begin
			mask_q <= '0;
			w_q    <= p_q[PW-1:6];
		end
		if (cmd.c_wr) w_q <= w_q + 1'b1;
	end

	// Memory port selection
	always_comb begin
		ra = cmd.s_eval ? AW'(w_q + 1'b1) : AW'(w_q);
		we = 1'b0;
		wa = AW'(w_q);
		wd = rdata;
		priority if (cmd.set_cur) begin
			we = 1'b1;
			wd = cur_raw_q | rmask(w_q, sp_q, ep_q);
		end else if (cmd.set_prev) begin
			we = 1'b1;
			wa = AW'(w_q - 1'b1);
			wd = prev_raw_q | rmask(w_q - 1'b1, sp_q, ep_q);
		end else if (cmd.f_wr) begin
			we = 1'b1;
			wd = rdata & ~mask_q;
		end else if (cmd.c_wr) begin
			we = 1'b1;
			wd = rdata & ~rmask(w_q, lo_q, hi_q);
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	// A word never written reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_WORDS; i++) vld_q[i] <= 1'b0;
			rdv_q <= 1'b0;
		end else begin
			if (we) vld_q[wa] <= 1'b1;
			rdv_q <= vld_q[ra];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.resp && sts.out_free) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp && sts.out_free) begin
			out_status         <= res_status_q;
			out_first_page     <= res_first_q;
			out_zone_free_left <= res_left_q;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		sts          = '0;
		sts.accept   = in_valid && cmd.in_ready;
		sts.clr_pend = (cq_n_q != '0);
		sts.chk_done = bad_cnt || bad_zone || short_cnt;
		sts.chk_free = (kind_q == KIND_FREE);
		sts.s_found  = |hits;
		sts.s_last   = (w_q == hm1_q[PW-1:6]);
		sts.s_span   = (sp_q[PW-1:6] != w_q);
		sts.f_flush  = (f_last || f_wchg) && (|mask_nx);
		sts.f_done   = f_last;
		sts.f_end    = (n_q == 6'd0);
		sts.c_last   = (w_q == hm1_q[PW-1:6]);
		sts.out_free = !ov_q || out_ready;
	end

endmodule
